/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define HCSR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hcsr assertion failed");

// checked at every edge, reset included
`define HCSR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("hcsr assertion failed");

`endif

/* hdl/hcsr_pkg.sv */
// shared types and constants of the height field span renderer
package hcsr_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_PIXEL_BITS = 8;

  localparam int unsigned COL_W      = 13;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned OUT_W      = 40;
  localparam int unsigned FIFO_DEPTH = 3;

  localparam int unsigned SHADE_DECAY  = 32;
  localparam int unsigned HEIGHT_SHIFT = 4;
  localparam int unsigned SLOPE_SHIFT  = 3;
  localparam int unsigned WIN_LEN      = 6;
  localparam logic [10:0] COL_SAT      = 11'd2047;

  typedef enum logic [2:0] {
    REG_MAX_HEIGHT   = 3'd0,
    REG_COLOR_HEIGHT = 3'd1,
    REG_MID_SHADE    = 3'd2,
    REG_DARK_SHADE   = 3'd3,
    REG_STEREO       = 3'd4,
    REG_FIRST_COL    = 3'd5,
    REG_END_COL      = 3'd6,
    REG_IMAGE_ROWS   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_RUN,
    ST_WB_END,
    ST_WB_NEXT
  } ctrl_state_e;

  typedef struct packed {
    logic [IDX_W-1:0] max_height;
    logic [IDX_W-1:0] color_height;
    logic [IDX_W-1:0] mid_shade;
    logic [IDX_W-1:0] dark_shade;
    logic             stereo;
  } shade_cfg_t;

  // column sits in the lowest bits
  typedef struct packed {
    logic [IDX_W-1:0] palette_index;
    logic [ROW_W-1:0] span_bottom;
    logic [ROW_W-1:0] span_top;
    logic [IDX_W-1:0] column;
  } span_t;

endpackage

/* hdl/hcsr_ram.sv */
// generic single write port ram with registered read
module hcsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/hcsr_span_calc.sv */
// height, shade and palette index arithmetic for one column
module hcsr_span_calc import hcsr_pkg::*; #(
  parameter int unsigned LVL_W = 13
) (
  input  shade_cfg_t              cfg_i,
  input  logic [ROW_W-1:0]        row_i,
  input  logic [LVL_W-1:0]        box_i,
  input  logic [LVL_W-1:0]        down2_i,
  input  logic signed [LVL_W:0]   shade_max_i,
  input  logic [ROW_W-1:0]        fill_i,
  output logic                    emit_o,
  output logic [ROW_W-1:0]        top_o,
  output logic [IDX_W-1:0]        index_o,
  output logic signed [LVL_W:0]   shade_o
);

  localparam int unsigned H_W = LVL_W - HEIGHT_SHIFT;
  localparam int unsigned V_W = LVL_W + 2;

  logic signed [LVL_W:0] box_s;
  logic signed [LVL_W:0] diff;
  logic signed [LVL_W:0] diff_adj;
  logic                  lit;
  logic [H_W-1:0]        h;
  logic                  h_over;
  logic [IDX_W-1:0]      cap;
  logic [IDX_W-1:0]      peak;
  logic [IDX_W-1:0]      shade_idx;
  logic signed [V_W-1:0] slope;
  logic signed [V_W-1:0] base;
  logic signed [V_W-1:0] max_s;
  logic signed [V_W-1:0] v;

  always_comb begin
    box_s   = $signed({1'b0, box_i});
    lit     = box_s > shade_max_i;
    shade_o = (lit ? box_s : shade_max_i) - $signed((LVL_W+1)'(SHADE_DECAY));

    // height and caps compared at full level width
    h      = box_i[LVL_W-1:HEIGHT_SHIFT];
    h_over = LVL_W'(h) > LVL_W'(cfg_i.max_height);
    cap    = h_over ? cfg_i.max_height : IDX_W'(h);
    top_o  = (cap > IDX_W'(row_i)) ? '0 : row_i - ROW_W'(cap);
    emit_o = top_o < fill_i;

    peak = (LVL_W'(h) >= LVL_W'(cfg_i.color_height)) ? cfg_i.color_height : IDX_W'(h);

    // truncating divide by eight of the slope
    diff     = $signed({1'b0, down2_i}) - box_s;
    diff_adj = (diff < 0) ? diff + $signed((LVL_W+1)'(7)) : diff;
    slope    = V_W'(diff_adj >>> SLOPE_SHIFT);
    base     = $signed(V_W'(lit ? cfg_i.mid_shade : cfg_i.dark_shade));
    max_s    = $signed(V_W'(cfg_i.max_height));
    v        = base - slope;
    if (v < 0) begin
      shade_idx = '0;
    end else if (v < max_s) begin
      shade_idx = v[IDX_W-1:0];
    end else begin
      shade_idx = cfg_i.max_height;
    end

    if (cfg_i.stereo) begin
      index_o = row_i;
    end else if (h_over) begin
      index_o = peak;
    end else begin
      index_o = shade_idx;
    end
  end

endmodule

/* hdl/hcsr_out_fifo.sv */
// small output queue that parts the pipeline from the span receiver
module hcsr_out_fifo import hcsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  span_t      data_i,
  input  logic       pop_i,
  output logic       valid_o,
  output span_t      data_o,
  output logic [1:0] count_o
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  span_t         mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          pop;

  assign valid_o = cnt_q != 2'd0;
  assign pop     = pop_i & valid_o;
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* hdl/heightfield_column_span_renderer.sv */
// top level of the height field column span renderer
//
// source pixels enter on the s_axis channel one per cycle while s_axis_tready
// is high, bottom row first; each accepted request may produce one span
// request on m_axis; a span for column x comes from the pixel of column x+6:
// the memories are read when that pixel is taken, the compute stage works on
// the registered read data, then the span is queued and offered; one pixel per
// cycle is sustained while the queue has room, set by the single
// read-modify-write pass through the per-column memories; configuration
// writes come in on the cfg channel and are taken at any time except while
// the edge copy is stored back; an end_column write while an edge copy is held
// passes through ST_WB_END and ST_WB_NEXT to store the edge copy registers
// back into the level and shade memories; after reset a clearing pass sweeps
// every entry of every column memory; a request with frame_start waits for
// the pipeline to drain and another pass before it is taken, and the fill
// lines then start at image_rows minus one; when the receiver stalls,
// finished spans wait in a three entry queue and s_axis_tready drops once the
// queued spans and the span in the compute stage fill it
module heightfield_column_span_renderer import hcsr_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int unsigned IN_W = ((PIXEL_BITS + ROW_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,  // pixel, row, zero fill
  input  logic [1:0]            s_axis_tuser,  // row_start, frame_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,  // column, span_top, span_bottom, palette_index
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SUM_W     = PIXEL_BITS + 3;
  localparam int unsigned LVL_W     = PIXEL_BITS + 5;
  localparam int unsigned LVL_DEPTH = MAX_WIDTH + 2;
  localparam int unsigned LAW       = $clog2(LVL_DEPTH);
  localparam int unsigned PAW       = $clog2(MAX_WIDTH);

  // configuration registers
  logic [IDX_W-1:0] max_height_q, color_height_q, mid_shade_q, dark_shade_q;
  logic             stereo_q;
  logic [9:0]       first_column_q;
  logic [10:0]      end_column_q, image_rows_q;
  logic             cfg_we;
  logic [COL_W-1:0] end_c;

  // control
  ctrl_state_e      state_q, state_d;
  logic [LAW-1:0]   sweep_idx_q;
  logic             sweep_fresh_q, swept_q, sweep_last;
  logic [COL_W-1:0] wb_end_q;
  logic [ROW_W-1:0] fill_base_q;

  // input side
  logic                  acc, rs_any, room;
  logic [PIXEL_BITS-1:0] pix;
  logic [ROW_W-1:0]      row;
  logic [PIXEL_BITS-1:0] win_q [WIN_LEN];
  logic [SUM_W-1:0]      win_sum_q, win_sum_d;
  logic [10:0]           cur_col_q, cur_col_d, col;
  logic [COL_W-1:0]      x;
  logic                  res_ok, hi;
  logic [LAW-1:0]        lvl_raddr;
  logic [PAW-1:0]        ps_raddr;

  // compute stage
  logic             s1_valid_q, s1_res_q, s1_copy_q, s1_hi_q;
  logic [COL_W-1:0] s1_x_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [SUM_W-1:0] s1_wsum_q;
  logic [LAW-1:0]   s1_lvl_raddr_q;
  logic [PAW-1:0]   s1_ps_raddr_q;

  // edge copy of columns end and end+1
  logic                  cp_valid_q;
  logic [LVL_W-1:0]      cp_lvl_q;
  logic signed [LVL_W:0] cp_shd_q;

  // memory ports
  logic                  lvl_we, ps0_we, ps1_we, fill_we;
  logic [LAW-1:0]        lvl_waddr;
  logic [PAW-1:0]        ps_waddr, fill_waddr;
  logic [LVL_W-1:0]      lvl_wdata, lvl_rd;
  logic [LVL_W:0]        shd_wdata, shd_rd;
  logic [SUM_W-1:0]      ps_wdata, ps0_rd, ps1_rd;
  logic [ROW_W:0]        fill_wdata, fill_rd;

  // last write, for read-during-write forwarding
  logic                  lw_lvl_we_q, lw_ps0_we_q, lw_ps1_we_q, lw_fill_we_q;
  logic [LAW-1:0]        lw_lvl_addr_q;
  logic [PAW-1:0]        lw_ps_addr_q, lw_fill_addr_q;
  logic [LVL_W-1:0]      lw_lvl_data_q;
  logic [LVL_W:0]        lw_shd_data_q;
  logic [SUM_W-1:0]      lw_ps_data_q;
  logic [ROW_W:0]        lw_fill_data_q;

  logic [LVL_W-1:0]      lvl_f, down2, box;
  logic signed [LVL_W:0] shd_f, shade_max, shade_new;
  logic [SUM_W-1:0]      ps0_f, ps1_f;
  logic [ROW_W:0]        fill_f;
  logic [ROW_W-1:0]      fill_val, top;
  logic [IDX_W-1:0]      pal_idx;
  logic                  emit, push;
  shade_cfg_t            shade_cfg;
  span_t                 span, out_span;
  logic [1:0]            fifo_count;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = (state_q == ST_RUN) || (state_q == ST_SWEEP);
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign end_c       = (COL_W'(end_column_q) > COL_W'(MAX_WIDTH)) ?
                       COL_W'(MAX_WIDTH) : COL_W'(end_column_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_height_q   <= 10'd255;
      color_height_q <= 10'd255;
      mid_shade_q    <= 10'd128;
      dark_shade_q   <= 10'd64;
      stereo_q       <= 1'b0;
      first_column_q <= 10'd0;
      end_column_q   <= 11'd1024;
      image_rows_q   <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MAX_HEIGHT:   max_height_q   <= cfg_data_i[IDX_W-1:0];
        REG_COLOR_HEIGHT: color_height_q <= cfg_data_i[IDX_W-1:0];
        REG_MID_SHADE:    mid_shade_q    <= cfg_data_i[IDX_W-1:0];
        REG_DARK_SHADE:   dark_shade_q   <= cfg_data_i[IDX_W-1:0];
        REG_STEREO:       stereo_q       <= cfg_data_i[0];
        REG_FIRST_COL:    first_column_q <= cfg_data_i[9:0];
        REG_END_COL:      end_column_q   <= cfg_data_i;
        REG_IMAGE_ROWS:   image_rows_q   <= cfg_data_i;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  assign sweep_last = sweep_idx_q == LAW'(LVL_DEPTH - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP: begin
        if (sweep_last) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (cfg_we && cfg_reg_e'(cfg_index_i) == REG_END_COL && cp_valid_q) begin
          state_d = ST_WB_END;
        end else if (s_axis_tvalid && s_axis_tuser[1] && !swept_q && !s1_valid_q) begin
          state_d = ST_SWEEP;
        end
      end
      ST_WB_END:  state_d = ST_WB_NEXT;
      ST_WB_NEXT: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      sweep_idx_q   <= '0;
      sweep_fresh_q <= 1'b0;
      swept_q       <= 1'b0;
      wb_end_q      <= '0;
      fill_base_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RUN && state_d == ST_SWEEP) begin
        sweep_idx_q   <= '0;
        sweep_fresh_q <= 1'b1;
      end else if (state_q == ST_SWEEP) begin
        sweep_idx_q <= sweep_idx_q + LAW'(1);
      end
      if (state_q == ST_SWEEP && sweep_last) begin
        swept_q <= sweep_fresh_q;
      end else if (acc && s_axis_tuser[1]) begin
        swept_q <= 1'b0;
      end
      if (cfg_we && cfg_reg_e'(cfg_index_i) == REG_END_COL) begin
        wb_end_q <= end_c;
      end
      if (acc && s_axis_tuser[1]) begin
        fill_base_q <= ROW_W'(image_rows_q - 11'd1);
      end
    end
  end

  // ---------------------------------------------------------------- input stage
  assign pix    = s_axis_tdata[PIXEL_BITS-1:0];
  assign row    = s_axis_tdata[PIXEL_BITS +: ROW_W];
  assign rs_any = s_axis_tuser[0] | s_axis_tuser[1];

  // a new pixel may enter while the queue can still take every span in flight
  assign room = (3'(fifo_count) + 3'(s1_valid_q)) < 3'(FIFO_DEPTH);
  assign s_axis_tready = (state_q == ST_RUN) && room && (!s_axis_tuser[1] || swept_q);
  assign acc = s_axis_tvalid & s_axis_tready;

  always_comb begin
    col       = rs_any ? {1'b0, first_column_q} : cur_col_q;
    cur_col_d = (col < COL_SAT) ? col + 11'd1 : col;
    x         = COL_W'(col) - COL_W'(WIN_LEN);
    res_ok    = (COL_W'(col) >= COL_W'(first_column_q) + COL_W'(WIN_LEN)) && (x < end_c);
    hi        = (x + COL_W'(2)) >= end_c;
    // a row start reads column end-1 for the edge copy, otherwise column x+2
    lvl_raddr = rs_any ? LAW'(end_c - COL_W'(1)) : LAW'(x + COL_W'(2));
    ps_raddr  = PAW'(x);
    win_sum_d = (rs_any ? '0 : win_sum_q - SUM_W'(win_q[WIN_LEN-1])) + SUM_W'(pix);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_LEN; i++) win_q[i] <= '0;
      win_sum_q <= '0;
      cur_col_q <= '0;
    end else if (acc) begin
      win_q[0] <= pix;
      for (int i = 1; i < WIN_LEN; i++) win_q[i] <= rs_any ? '0 : win_q[i-1];
      win_sum_q <= win_sum_d;
      cur_col_q <= cur_col_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
      s1_copy_q  <= 1'b0;
    end else begin
      s1_valid_q <= acc;
      if (acc) begin
        s1_res_q  <= res_ok;
        s1_copy_q <= rs_any && (end_c != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_hi_q        <= hi;
      s1_x_q         <= x;
      s1_row_q       <= row;
      s1_wsum_q      <= win_sum_d;
      s1_lvl_raddr_q <= lvl_raddr;
      s1_ps_raddr_q  <= ps_raddr;
    end
  end

  // ---------------------------------------------------------------- memories
  hcsr_ram #(.WIDTH(LVL_W), .DEPTH(LVL_DEPTH)) u_level_ram (
    .clk_i, .we_i(lvl_we), .waddr_i(lvl_waddr), .wdata_i(lvl_wdata),
    .raddr_i(lvl_raddr), .rdata_o(lvl_rd)
  );

  hcsr_ram #(.WIDTH(LVL_W + 1), .DEPTH(LVL_DEPTH)) u_shade_ram (
    .clk_i, .we_i(lvl_we), .waddr_i(lvl_waddr), .wdata_i(shd_wdata),
    .raddr_i(lvl_raddr), .rdata_o(shd_rd)
  );

  hcsr_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_sum_even_ram (
    .clk_i, .we_i(ps0_we), .waddr_i(ps_waddr), .wdata_i(ps_wdata),
    .raddr_i(ps_raddr), .rdata_o(ps0_rd)
  );

  hcsr_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_sum_odd_ram (
    .clk_i, .we_i(ps1_we), .waddr_i(ps_waddr), .wdata_i(ps_wdata),
    .raddr_i(ps_raddr), .rdata_o(ps1_rd)
  );

  // top bit marks an entry still at the frame's starting fill line
  hcsr_ram #(.WIDTH(ROW_W + 1), .DEPTH(MAX_WIDTH)) u_fill_ram (
    .clk_i, .we_i(fill_we), .waddr_i(fill_waddr), .wdata_i(fill_wdata),
    .raddr_i(ps_raddr), .rdata_o(fill_rd)
  );

  // write port selection
  always_comb begin
    lvl_we     = 1'b0;
    lvl_waddr  = LAW'(s1_x_q);
    lvl_wdata  = box;
    shd_wdata  = shade_new;
    ps0_we     = 1'b0;
    ps1_we     = 1'b0;
    ps_waddr   = PAW'(s1_x_q);
    ps_wdata   = s1_wsum_q;
    fill_we    = 1'b0;
    fill_waddr = PAW'(s1_x_q);
    fill_wdata = {1'b0, top};
    unique case (state_q)
      ST_SWEEP: begin
        lvl_we     = 1'b1;
        lvl_waddr  = sweep_idx_q;
        lvl_wdata  = '0;
        shd_wdata  = '0;
        ps0_we     = COL_W'(sweep_idx_q) < COL_W'(MAX_WIDTH);
        ps1_we     = ps0_we;
        ps_waddr   = PAW'(sweep_idx_q);
        ps_wdata   = '0;
        fill_we    = ps0_we;
        fill_waddr = PAW'(sweep_idx_q);
        fill_wdata = {sweep_fresh_q, {ROW_W{1'b0}}};
      end
      ST_WB_END: begin
        lvl_we    = 1'b1;
        lvl_waddr = LAW'(wb_end_q);
        lvl_wdata = cp_lvl_q;
        shd_wdata = cp_shd_q;
      end
      ST_WB_NEXT: begin
        lvl_we    = 1'b1;
        lvl_waddr = LAW'(wb_end_q + COL_W'(1));
        lvl_wdata = cp_lvl_q;
        shd_wdata = cp_shd_q;
      end
      ST_RUN: begin
        lvl_we  = s1_valid_q & s1_res_q;
        ps0_we  = lvl_we & ~s1_row_q[0];
        ps1_we  = lvl_we & s1_row_q[0];
        fill_we = lvl_we & emit;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_lvl_we_q  <= 1'b0;
      lw_ps0_we_q  <= 1'b0;
      lw_ps1_we_q  <= 1'b0;
      lw_fill_we_q <= 1'b0;
    end else begin
      lw_lvl_we_q  <= lvl_we;
      lw_ps0_we_q  <= ps0_we;
      lw_ps1_we_q  <= ps1_we;
      lw_fill_we_q <= fill_we;
    end
  end

  always_ff @(posedge clk_i) begin
    lw_lvl_addr_q  <= lvl_waddr;
    lw_lvl_data_q  <= lvl_wdata;
    lw_shd_data_q  <= shd_wdata;
    lw_ps_addr_q   <= ps_waddr;
    lw_ps_data_q   <= ps_wdata;
    lw_fill_addr_q <= fill_waddr;
    lw_fill_data_q <= fill_wdata;
  end

  // ---------------------------------------------------------------- compute stage
  always_comb begin
    // a write at the edge of the read wins over the stale read data
    if (lw_lvl_we_q && lw_lvl_addr_q == s1_lvl_raddr_q) begin
      lvl_f = lw_lvl_data_q;
      shd_f = $signed(lw_shd_data_q);
    end else begin
      lvl_f = lvl_rd;
      shd_f = $signed(shd_rd);
    end
    ps0_f  = (lw_ps0_we_q && lw_ps_addr_q == s1_ps_raddr_q) ? lw_ps_data_q : ps0_rd;
    ps1_f  = (lw_ps1_we_q && lw_ps_addr_q == s1_ps_raddr_q) ? lw_ps_data_q : ps1_rd;
    fill_f = (lw_fill_we_q && lw_fill_addr_q == s1_ps_raddr_q) ? lw_fill_data_q : fill_rd;

    fill_val  = fill_f[ROW_W] ? fill_base_q : fill_f[ROW_W-1:0];
    box       = LVL_W'(s1_wsum_q) + LVL_W'(ps0_f) + LVL_W'(ps1_f);
    // columns end and end+1 come from the edge copy once a row has started
    down2     = (cp_valid_q && s1_hi_q) ? cp_lvl_q : lvl_f;
    shade_max = (cp_valid_q && s1_hi_q) ? cp_shd_q : shd_f;

    shade_cfg.max_height   = max_height_q;
    shade_cfg.color_height = color_height_q;
    shade_cfg.mid_shade    = mid_shade_q;
    shade_cfg.dark_shade   = dark_shade_q;
    shade_cfg.stereo       = stereo_q;
  end

  hcsr_span_calc #(.LVL_W(LVL_W)) u_span_calc (
    .cfg_i       (shade_cfg),
    .row_i       (s1_row_q),
    .box_i       (box),
    .down2_i     (down2),
    .shade_max_i (shade_max),
    .fill_i      (fill_val),
    .emit_o      (emit),
    .top_o       (top),
    .index_o     (pal_idx),
    .shade_o     (shade_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_valid_q <= 1'b0;
      cp_lvl_q   <= '0;
      cp_shd_q   <= '0;
    end else if ((state_q == ST_SWEEP && sweep_last) || state_q == ST_WB_NEXT) begin
      cp_valid_q <= 1'b0;
    end else if (s1_valid_q && s1_copy_q) begin
      cp_valid_q <= 1'b1;
      cp_lvl_q   <= lvl_f;
      cp_shd_q   <= shd_f;
    end
  end

  // ---------------------------------------------------------------- output
  assign push               = s1_valid_q & s1_res_q & emit & (state_q == ST_RUN);
  assign span.column        = s1_x_q[IDX_W-1:0];
  assign span.span_top      = top;
  assign span.span_bottom   = fill_val;
  assign span.palette_index = pal_idx;

  hcsr_out_fifo u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (span),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_span),
    .count_o (fifo_count)
  );

  assign m_axis_tdata = out_span;

endmodule

/* hdl/hcsr_checker.sv */
// port level checks of the span renderer, bound to the top level
module hcsr_checker import hcsr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             cfg_ready_o
);

`include "assert_macros.svh"

  // a stalled span stays offered and unchanged
  `HCSR_ASSERT(a_span_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // a span always lies strictly above the old fill line
  `HCSR_ASSERT(a_span_order, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[19:10] < m_axis_tdata[29:20])

  // while the edge copy is stored back no pixel is taken
  `HCSR_ASSERT_ALWAYS(a_wb_blocks_input, clk_i, !cfg_ready_o |-> !s_axis_tready)

endmodule

bind heightfield_column_span_renderer hcsr_checker u_hcsr_checker (.*);
